// ===== sv/bitmap_shape_fill_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap shape fill engine
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SHAPE_FILL_ENGINE_ASSERT_SVH
`define BITMAP_SHAPE_FILL_ENGINE_ASSERT_SVH

// same-cycle implication
`define BSFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types, codes and helpers of the bitmap shape fill engine.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int ROW_W       = 64;
  localparam int Q_DEPTH     = 2;

  localparam logic [1:0] KIND_SQUARE = 2'd0;
  localparam logic [1:0] KIND_TRI    = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] ST_DRAWN = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_READ,
    OP_REPORT
  } op_t;

  // how the row mask evolves from one row to the next
  typedef enum logic [1:0] {
    MD_HOLD,
    MD_DROP_HI,
    MD_DROP_LO,
    MD_SLIDE
  } mode_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        status;
    logic signed [7:0] row0;
    logic              up;
    logic [6:0]        count;
    logic [ROW_W-1:0]  mask;
    mode_t             mode;
    logic [6:0]        lim;
  } cmd_t;

  // len bits set starting at column lo
  function automatic logic [ROW_W-1:0] span(input logic [6:0] lo, input logic [6:0] len);
    logic [ROW_W-1:0] m;
    m = '0;
    if (len != 7'd0 && lo < 7'(ROW_W)) begin
      if (len >= 7'(ROW_W)) m = '1;
      else m = (ROW_W'(1) << len) - ROW_W'(1);
      m = m << lo;
    end
    return m;
  endfunction

endpackage

// ===== sv/bsfe_front.sv =====
// ----------------------------------------------------------------------------
// bsfe_front
// Holds the board size, range-checks each command and turns it into a
// row-walk descriptor for the back end.
// ----------------------------------------------------------------------------
module bsfe_front import bsfe_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [6:0] in_extent,
  input  logic [5:0] in_x_start,
  input  logic [5:0] in_y_start,
  input  logic [5:0] in_x_end,
  input  logic [5:0] in_y_end,
  input  logic [1:0] in_corner,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam logic [6:0] DIM_MAX = 7'(MAX_DIM);

  logic [6:0] cols_r, rows_r;

  function automatic logic [6:0] clamp_dim(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= DIM_MAX;
      rows_r <= DIM_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLS: cols_r <= clamp_dim(cfg_data);
        CFG_ROWS: rows_r <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  logic signed [8:0] xs9, ys9, w9, n9, m9;
  logic              left, up_dir;
  logic              sq_oor, tri_oor, line_oor;
  logic [5:0]        lx1, ly1, lx2, ly2, ymin, ymax;

  always_comb begin
    xs9    = $signed({3'b000, in_x_start});
    ys9    = $signed({3'b000, in_y_start});
    w9     = $signed({2'b00, in_extent});
    n9     = $signed({2'b00, cols_r});
    m9     = $signed({2'b00, rows_r});
    left   = in_corner[0];
    up_dir = in_corner[1];

    sq_oor = (({2'b00, in_x_start} + {1'b0, in_extent}) > {1'b0, cols_r}) ||
             (({2'b00, in_y_start} + {1'b0, in_extent}) > {1'b0, rows_r});

    tri_oor = 1'b0;
    if (left) begin
      if ((xs9 - w9 + 9'sd1 < 9'sd0) || (xs9 >= n9)) tri_oor = 1'b1;
    end else begin
      if (xs9 + w9 - 9'sd1 >= n9) tri_oor = 1'b1;
    end
    if (up_dir) begin
      if ((ys9 - w9 + 9'sd1 < 9'sd0) || (ys9 >= m9)) tri_oor = 1'b1;
    end else begin
      if (ys9 + w9 - 9'sd1 >= m9) tri_oor = 1'b1;
    end

    line_oor = ({1'b0, in_x_start} >= cols_r) || ({1'b0, in_x_end} >= cols_r) ||
               ({1'b0, in_y_start} >= rows_r) || ({1'b0, in_y_end} >= rows_r);

    // order endpoints by column
    if (in_x_end < in_x_start) begin
      lx1 = in_x_end;   ly1 = in_y_end;
      lx2 = in_x_start; ly2 = in_y_start;
    end else begin
      lx1 = in_x_start; ly1 = in_y_start;
      lx2 = in_x_end;   ly2 = in_y_end;
    end
    ymin = (in_y_start < in_y_end) ? in_y_start : in_y_end;
    ymax = (in_y_start < in_y_end) ? in_y_end : in_y_start;

    q_cmd        = '0;
    q_cmd.op     = OP_DRAW;
    q_cmd.status = ST_DRAWN;
    q_cmd.mode   = MD_HOLD;
    q_cmd.lim    = rows_r;

    case (in_kind)
      KIND_SQUARE: begin
        if (sq_oor) begin
          q_cmd.op     = OP_REPORT;
          q_cmd.status = ST_RANGE;
        end else begin
          q_cmd.row0  = $signed({2'b00, in_y_start});
          q_cmd.count = in_extent;
          q_cmd.mask  = span({1'b0, in_x_start}, in_extent);
        end
      end
      KIND_TRI: begin
        if (tri_oor) begin
          q_cmd.op     = OP_REPORT;
          q_cmd.status = ST_RANGE;
        end else begin
          q_cmd.row0  = $signed({2'b00, in_y_start});
          q_cmd.up    = up_dir;
          q_cmd.count = in_extent;
          q_cmd.mask  = span(left ? 7'(xs9 - w9 + 9'sd1) : {1'b0, in_x_start}, in_extent);
          q_cmd.mode  = left ? MD_DROP_LO : MD_DROP_HI;
        end
      end
      KIND_LINE: begin
        if (line_oor) begin
          q_cmd.op     = OP_REPORT;
          q_cmd.status = ST_RANGE;
        end else if (lx1 == lx2) begin
          q_cmd.row0  = $signed({2'b00, ymin});
          q_cmd.count = {1'b0, ymax - ymin} + 7'd1;
          q_cmd.mask  = span({1'b0, lx1}, 7'd1);
        end else if (ly1 == ly2) begin
          q_cmd.row0  = $signed({2'b00, ly1});
          q_cmd.count = 7'd1;
          q_cmd.mask  = span({1'b0, lx1}, {1'b0, lx2 - lx1} + 7'd1);
        end else begin
          q_cmd.row0  = $signed({2'b00, ly1});
          q_cmd.up    = ly1 > ly2;
          q_cmd.count = {1'b0, lx2 - lx1} + 7'd1;
          q_cmd.mask  = span({1'b0, lx1}, 7'd1);
          q_cmd.mode  = MD_SLIDE;
        end
      end
      default: begin
        if ({1'b0, in_y_start} >= rows_r) begin
          q_cmd.op     = OP_REPORT;
          q_cmd.status = ST_RANGE;
        end else begin
          q_cmd.op   = OP_READ;
          q_cmd.row0 = $signed({2'b00, in_y_start});
          q_cmd.mask = span(7'd0, cols_r);
        end
      end
    endcase
  end

endmodule

// ===== sv/bsfe_queue.sv =====
// ----------------------------------------------------------------------------
// bsfe_queue
// Short command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module bsfe_queue import bsfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  cmd_t             slot_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;

  assign full    = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bsfe_back.sv =====
// ----------------------------------------------------------------------------
// bsfe_back
// Walks a command's rows one per cycle, doing a read-modify-write of the
// bitmap memory, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module bsfe_back import bsfe_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ROW_W-1:0]  out_row_bits
);

  localparam int AW = $clog2(MAX_DIM);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_READ_WAIT,
    S_DONE
  } state_t;

  state_t             state_r;
  logic signed [7:0]  row_r;
  logic               up_r;
  logic [6:0]         cnt_r;
  logic [ROW_W-1:0]   mask_r;
  mode_t              mode_r;
  logic [6:0]         lim_r;

  logic               p_vld_r;
  logic [AW-1:0]      p_addr_r;
  logic [MAX_DIM-1:0] p_mask_r;

  logic [MAX_DIM-1:0] mem [MAX_DIM];
  logic [MAX_DIM-1:0] rd_q;
  logic               rd_hit_r;
  logic [MAX_DIM-1:0] vld_r;

  logic [1:0]         res_status_r;
  logic [ROW_W-1:0]   res_bits_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ROW_W-1:0]   out_bits_r;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               row_in;
  logic [MAX_DIM-1:0] wdata;
  logic [MAX_DIM-1:0] rd_eff;
  logic [ROW_W-1:0]   rd_ext;
  logic [ROW_W-1:0]   mask_step;

  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign row_in = !row_r[7] && (row_r[6:0] < lim_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_r[AW-1:0];
    if (q_pop && q_cmd.op == OP_READ) begin
      rd_en   = 1'b1;
      rd_addr = q_cmd.row0[AW-1:0];
    end else if (state_r == S_RUN && row_in) begin
      rd_en = 1'b1;
    end
  end

  // pixels never written read as blank
  assign rd_eff = rd_hit_r ? rd_q : '0;
  assign wdata  = rd_eff | p_mask_r;

  always_comb begin
    rd_ext = '0;
    rd_ext[MAX_DIM-1:0] = rd_eff;
    case (mode_r)
      MD_DROP_HI: mask_step = mask_r & (mask_r >> 1);
      MD_DROP_LO: mask_step = mask_r & (mask_r << 1);
      MD_SLIDE:   mask_step = mask_r << 1;
      default:    mask_step = mask_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_vld_r) mem[p_addr_r] <= wdata;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      vld_r       <= '0;
    end else begin
      // rows of a diagonal that leave the board are skipped
      p_vld_r     <= (state_r == S_RUN) && row_in;
      out_valid_r <= (state_r == S_DONE) || (out_valid_r && out_stall);
      if (p_vld_r) vld_r[p_addr_r] <= 1'b1;
      if (rd_en) rd_hit_r <= vld_r[rd_addr];

      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            row_r        <= q_cmd.row0;
            up_r         <= q_cmd.up;
            cnt_r        <= q_cmd.count;
            mask_r       <= q_cmd.mask;
            mode_r       <= q_cmd.mode;
            lim_r        <= q_cmd.lim;
            res_status_r <= q_cmd.status;
            res_bits_r   <= '0;
            case (q_cmd.op)
              OP_READ: state_r <= S_READ_WAIT;
              OP_DRAW: state_r <= (q_cmd.count == 7'd0) ? S_DONE : S_RUN;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_RUN: begin
          p_addr_r <= row_r[AW-1:0];
          p_mask_r <= mask_r[MAX_DIM-1:0];
          row_r    <= up_r ? row_r - 8'sd1 : row_r + 8'sd1;
          cnt_r    <= cnt_r - 7'd1;
          mask_r   <= mask_step;
          if (cnt_r == 7'd1) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          res_status_r <= ST_DRAWN;
          state_r      <= S_DONE;
        end
        S_READ_WAIT: begin
          res_status_r <= ST_ROW;
          res_bits_r   <= rd_ext & mask_r;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_status_r <= res_status_r;
            out_bits_r   <= res_bits_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_row_bits = out_bits_r;

endmodule

// ===== sv/bitmap_shape_fill_engine.sv =====
// ----------------------------------------------------------------------------
// bitmap_shape_fill_engine
// Each draw command walks count rows (extent, run length or column span),
// with one memory read-modify-write per row. The back end takes a new command
// from the queue only after the previous result has been registered for output.
// Reset clears the bitmap at once via per-row valid bits; the board is up to
// MAX_DIM x MAX_DIM, 64 x 64 by default.
// ----------------------------------------------------------------------------
`include "bitmap_shape_fill_engine_assert.svh"

module bitmap_shape_fill_engine import bsfe_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [6:0]        in_extent,
  input  logic [5:0]        in_x_start,
  input  logic [5:0]        in_y_start,
  input  logic [5:0]        in_x_end,
  input  logic [5:0]        in_y_end,
  input  logic [1:0]        in_corner,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [ROW_W-1:0]  out_row_bits
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, pop_cmd;

  bsfe_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_extent  (in_extent),
    .in_x_start (in_x_start),
    .in_y_start (in_y_start),
    .in_x_end   (in_x_end),
    .in_y_end   (in_y_end),
    .in_corner  (in_corner),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  bsfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  bsfe_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_row_bits (out_row_bits)
  );

  `BSFE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "command popped from empty queue")
  `BSFE_ASSERT_IMP(a_push_room, q_push, !q_full, "command pushed into full queue")
  `BSFE_ASSERT_NXT(a_push_lands, q_push && q_empty, !q_empty, "pushed command was lost")
  `BSFE_ASSERT_IMP(a_bits_on_read, out_valid && (out_status != ST_ROW), out_row_bits == '0, "row bits on a non-read result")

endmodule

// ===== test/shape_fill_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_fill_checker
// Watches the register, command and result channels of the bitmap shape fill
// engine, keeps its own copy of the bitmap and board size, predicts the reply
// of every accepted command and compares each result beat, in order.
// ----------------------------------------------------------------------------
module shape_fill_checker import bsfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [6:0]       cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_kind,
  input  logic [6:0]       in_extent,
  input  logic [5:0]       in_x_start,
  input  logic [5:0]       in_y_start,
  input  logic [5:0]       in_x_end,
  input  logic [5:0]       in_y_end,
  input  logic [1:0]       in_corner,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_status,
  input  logic [ROW_W-1:0] out_row_bits,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic [1:0]       status;
    logic [ROW_W-1:0] row_bits;
  } reply_t;

  logic [ROW_W-1:0] board [0:MAX_DIM_DEF-1];
  int               cols;
  int               rows;
  reply_t           replies_due [$];
  reply_t           want;
  reply_t           fresh;
  int               beat_no;

  function automatic int dim_of(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'(MAX_DIM_DEF)) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic logic [ROW_W-1:0] run_mask(input int lo, input int len);
    logic [ROW_W-1:0] m;
    m = '0;
    if (len > 0 && lo >= 0 && lo < ROW_W) begin
      if (len >= ROW_W) m = '1;
      else m = (64'd1 << len) - 64'd1;
      m = m << lo;
    end
    return m;
  endfunction

  task automatic mark_row(input int row, input logic [ROW_W-1:0] mask);
    if (row >= 0 && row < MAX_DIM_DEF) board[row] = board[row] | mask;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH beat %0d: %s", $time, beat_no, msg);
    mismatches++;
  endtask

  // applies one command to the local bitmap and returns its reply
  task automatic draw_cmd(input logic [1:0] kind, input int w, input int xs, input int ys,
                          input int xe, input int ye, input logic [1:0] corner,
                          output reply_t r);
    int  k, len, lo, row, i, j, dir, x1, y1, x2, y2, t;
    bit  left, up;
    r.status   = ST_DRAWN;
    r.row_bits = '0;
    left = corner[0];
    up   = corner[1];
    case (kind)
      KIND_SQUARE: begin
        if (xs + w > cols || ys + w > rows) r.status = ST_RANGE;
        else for (k = 0; k < w; k++) mark_row(ys + k, run_mask(xs, w));
      end
      KIND_TRI: begin
        if (left ? (xs - w + 1 < 0 || xs >= cols) : (xs + w - 1 >= cols))
          r.status = ST_RANGE;
        else if (up ? (ys - w + 1 < 0 || ys >= rows) : (ys + w - 1 >= rows))
          r.status = ST_RANGE;
        else begin
          for (k = 0; k < w; k++) begin
            len = w - k;
            lo  = left ? xs - len + 1 : xs;
            row = up ? ys - k : ys + k;
            mark_row(row, run_mask(lo, len));
          end
        end
      end
      KIND_LINE: begin
        if (xs >= cols || xe >= cols || ys >= rows || ye >= rows) r.status = ST_RANGE;
        else begin
          x1 = xs; y1 = ys; x2 = xe; y2 = ye;
          if (x2 < x1) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
          end
          if (x1 == x2) begin
            if (y1 > y2) begin
              t = y1; y1 = y2; y2 = t;
            end
            for (i = y1; i <= y2; i++) mark_row(i, run_mask(x1, 1));
          end else if (y1 == y2) begin
            mark_row(y1, run_mask(x1, x2 - x1 + 1));
          end else begin
            // one column and one row per pixel; rows off the board are dropped
            dir = (y1 > y2) ? -1 : 1;
            j = y1;
            for (i = x1; i <= x2; i++) begin
              if (j >= 0 && j < rows) mark_row(j, run_mask(i, 1));
              j += dir;
            end
          end
        end
      end
      default: begin
        if (ys >= rows) r.status = ST_RANGE;
        else begin
          r.status   = ST_ROW;
          r.row_bits = board[ys] & run_mask(0, cols);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_DIM_DEF; r++) board[r] = '0;
      cols = MAX_DIM_DEF;
      rows = MAX_DIM_DEF;
      replies_due.delete();
      mismatches = 0;
      beat_no = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLS) cols = dim_of(cfg_data);
        else if (cfg_index == CFG_ROWS) rows = dim_of(cfg_data);
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, status %0d", out_status));
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_row_bits !== want.row_bits)
            report_mismatch($sformatf("row_bits %h, want %h", out_row_bits, want.row_bits));
        end
        beat_no++;
      end
      if (in_valid && !in_stall) begin
        draw_cmd(in_kind, int'(in_extent), int'(in_x_start), int'(in_y_start),
                 int'(in_x_end), int'(in_y_end), in_corner, fresh);
        replies_due.push_back(fresh);
      end
      outstanding <= replies_due.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bitmap shape fill engine: directed squares, triangles in
// every direction, lines and row reads; random phases over a range of board
// sizes; full-size shapes and a shrunk board last; random command gaps and result stalls.
// ----------------------------------------------------------------------------
module tb import bsfe_pkg::*; ();

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 72;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 166;

  localparam logic [1:0] CORNER_RD = 2'd0;
  localparam logic [1:0] CORNER_LD = 2'd1;
  localparam logic [1:0] CORNER_RU = 2'd2;
  localparam logic [1:0] CORNER_LU = 2'd3;

  // register indexes the block has no register behind
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [6:0]       cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_kind;
  logic [6:0]       in_extent;
  logic [5:0]       in_x_start;
  logic [5:0]       in_y_start;
  logic [5:0]       in_x_end;
  logic [5:0]       in_y_end;
  logic [1:0]       in_corner;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [ROW_W-1:0] out_row_bits;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int board_cols;
  int board_rows;
  bit tx_quiet;
  bit rx_quiet;
  int rx_wait;
  int rx_draw;
  int rx_epoch;

  bitmap_shape_fill_engine uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_extent    (in_extent),
    .in_x_start   (in_x_start),
    .in_y_start   (in_y_start),
    .in_x_end     (in_x_end),
    .in_y_end     (in_y_end),
    .in_corner    (in_corner),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_row_bits (out_row_bits)
  );

  shape_fill_checker fill_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_extent    (in_extent),
    .in_x_start   (in_x_start),
    .in_y_start   (in_y_start),
    .in_x_end     (in_x_end),
    .in_y_end     (in_y_end),
    .in_corner    (in_corner),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_row_bits (out_row_bits),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_shape_fill_engine test failed");
      $finish;
    end
  end

  // result side: a random stall after each beat, the odd unprompted stall,
  // and quiet stretches with no stall at all
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      rx_quiet  <= 1'b0;
      rx_epoch  <= 0;
    end else begin
      rx_epoch <= rx_epoch + 1;
      if (rx_epoch % 300 == 0) rx_quiet <= ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        rx_draw = rx_quiet ? 0 : $urandom_range(0, 16);
        rx_wait   <= rx_draw;
        out_stall <= (rx_draw != 0);
      end else if (rx_wait > 0) begin
        rx_wait   <= rx_wait - 1;
        out_stall <= (rx_wait > 1);
      end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
        rx_draw = $urandom_range(1, 16);
        rx_wait   <= rx_draw;
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int eff_dim(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'(MAX_DIM_DEF)) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_board(input logic [6:0] c, input logic [6:0] r);
    write_reg(CFG_COLS, c);
    write_reg(CFG_ROWS, r);
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 7'($urandom_range(0, 127)));
    cfg_valid <= 1'b0;
    board_cols = eff_dim(c);
    board_rows = eff_dim(r);
  endtask

  task automatic issue_cmd(input logic [1:0] kind, input logic [6:0] w,
                           input logic [5:0] xs, input logic [5:0] ys,
                           input logic [5:0] xe, input logic [5:0] ye,
                           input logic [1:0] corner);
    int  gap;
    bit  drain;
    gap   = tx_quiet ? 0 : $urandom_range(0, 16);
    drain = ($urandom_range(0, 49) == 0);
    if (gap > 0 || drain) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) wait_idle();
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_extent  <= w;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    in_corner  <= corner;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly commands that fit the board, with a share of raw random ones
  task automatic random_cmd();
    logic [1:0] kind;
    logic [1:0] corner;
    int         pick, w, xs, ys, xe, ye, lim, sz;
    pick = $urandom_range(0, 99);
    kind = (pick < 20) ? KIND_SQUARE : (pick < 45) ? KIND_TRI :
           (pick < 75) ? KIND_LINE : KIND_READ;
    w      = $urandom_range(0, 64);
    xs     = $urandom_range(0, 63);
    ys     = $urandom_range(0, 63);
    xe     = $urandom_range(0, 63);
    ye     = $urandom_range(0, 63);
    corner = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 8) begin
      sz = $urandom_range(0, 99);
      w  = (sz < 70) ? $urandom_range(0, 6) : (sz < 98) ? $urandom_range(0, 16) :
           $urandom_range(0, 64);
      lim = (board_cols < board_rows) ? board_cols : board_rows;
      if (w > lim) w = lim;
      case (kind)
        KIND_SQUARE: begin
          xs = $urandom_range(0, (w == 0) ? board_cols - 1 : board_cols - w);
          ys = $urandom_range(0, (w == 0) ? board_rows - 1 : board_rows - w);
        end
        KIND_TRI: begin
          if (corner[0]) xs = $urandom_range((w == 0) ? 0 : w - 1, board_cols - 1);
          else xs = $urandom_range(0, (w == 0) ? board_cols - 1 : board_cols - w);
          if (corner[1]) ys = $urandom_range((w == 0) ? 0 : w - 1, board_rows - 1);
          else ys = $urandom_range(0, (w == 0) ? board_rows - 1 : board_rows - w);
        end
        KIND_LINE: begin
          xs = $urandom_range(0, board_cols - 1);
          xe = $urandom_range(0, board_cols - 1);
          ys = $urandom_range(0, board_rows - 1);
          ye = $urandom_range(0, board_rows - 1);
          case ($urandom_range(0, 3))
            0: ye = ys;
            1: xe = xs;
            default: ;
          endcase
        end
        default: ys = $urandom_range(0, board_rows - 1);
      endcase
    end
    issue_cmd(kind, 7'(w), 6'(xs), 6'(ys), 6'(xe), 6'(ye), corner);
  endtask

  initial begin : stimulus
    logic [6:0] phase_cols [PHASES];
    logic [6:0] phase_rows [PHASES];
    int         p, i;
    rst_n       <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_COLS;
    cfg_data    <= 7'd0;
    in_valid    <= 1'b0;
    in_kind     <= KIND_SQUARE;
    in_extent   <= 7'd0;
    in_x_start  <= 6'd0;
    in_y_start  <= 6'd0;
    in_x_end    <= 6'd0;
    in_y_end    <= 6'd0;
    in_corner   <= CORNER_RD;
    board_cols = MAX_DIM_DEF;
    board_rows = MAX_DIM_DEF;
    tx_quiet   = 1'b0;
    phase_cols = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd0, 7'd0};
    phase_rows = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd64, 7'd3, 7'd0, 7'd0};
    phase_cols[6] = 7'($urandom_range(1, 64));
    phase_rows[6] = 7'($urandom_range(1, 64));
    phase_cols[7] = 7'($urandom_range(0, 127));
    phase_rows[7] = 7'($urandom_range(0, 127));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass on the reset-size board
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd0,  6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd63, 6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_SQUARE, 7'd0,  6'd5,  6'd5,  6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_SQUARE, 7'd3,  6'd61, 6'd61, 6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_SQUARE, 7'd3,  6'd62, 6'd0,  6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_SQUARE, 7'd64, 6'd1,  6'd0,  6'd63, 6'd63, CORNER_LU);
    issue_cmd(KIND_TRI,    7'd4,  6'd0,  6'd0,  6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_TRI,    7'd4,  6'd63, 6'd0,  6'd0,  6'd0,  CORNER_LD);
    issue_cmd(KIND_TRI,    7'd4,  6'd0,  6'd63, 6'd0,  6'd0,  CORNER_RU);
    issue_cmd(KIND_TRI,    7'd4,  6'd63, 6'd63, 6'd0,  6'd0,  CORNER_LU);
    issue_cmd(KIND_TRI,    7'd5,  6'd3,  6'd10, 6'd0,  6'd0,  CORNER_LD);
    issue_cmd(KIND_TRI,    7'd5,  6'd10, 6'd3,  6'd0,  6'd0,  CORNER_RU);
    issue_cmd(KIND_TRI,    7'd0,  6'd9,  6'd9,  6'd0,  6'd0,  CORNER_LU);
    issue_cmd(KIND_LINE,   7'd0,  6'd0,  6'd20, 6'd63, 6'd20, CORNER_RD);
    issue_cmd(KIND_LINE,   7'd0,  6'd40, 6'd63, 6'd40, 6'd0,  CORNER_RD);
    issue_cmd(KIND_LINE,   7'd0,  6'd10, 6'd30, 6'd20, 6'd40, CORNER_RD);
    issue_cmd(KIND_LINE,   7'd0,  6'd30, 6'd50, 6'd25, 6'd55, CORNER_RD);
    issue_cmd(KIND_LINE,   7'd0,  6'd7,  6'd7,  6'd7,  6'd7,  CORNER_RD);
    // diagonal running off the bottom edge
    issue_cmd(KIND_LINE,   7'd0,  6'd0,  6'd62, 6'd10, 6'd63, CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd0,  6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd20, 6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd40, 6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd55, 6'd0,  6'd0,  CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd63, 6'd0,  6'd0,  CORNER_RD);
    in_valid <= 1'b0;
    settle();

    for (p = 0; p < PHASES; p++) begin
      set_board(phase_cols[p], phase_rows[p]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        random_cmd();
      end
      in_valid <= 1'b0;
      settle();
    end

    // full-size shapes last so the random part sees a sparse board
    tx_quiet = 1'b0;
    set_board(7'd64, 7'd64);
    issue_cmd(KIND_TRI,    7'd64, 6'd63, 6'd63, 6'd0, 6'd0, CORNER_LU);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd0,  6'd0, 6'd0, CORNER_RD);
    issue_cmd(KIND_TRI,    7'd64, 6'd0,  6'd0,  6'd0, 6'd0, CORNER_RD);
    issue_cmd(KIND_TRI,    7'd64, 6'd63, 6'd0,  6'd0, 6'd0, CORNER_LD);
    issue_cmd(KIND_TRI,    7'd64, 6'd0,  6'd63, 6'd0, 6'd0, CORNER_RU);
    issue_cmd(KIND_SQUARE, 7'd64, 6'd0,  6'd0,  6'd0, 6'd0, CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd31, 6'd0, 6'd0, CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd63, 6'd0, 6'd0, CORNER_RD);
    in_valid <= 1'b0;
    settle();
    // shrink the board: stored pixels stay, reads are masked
    set_board(7'd10, 7'd64);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd5,  6'd0, 6'd0, CORNER_RD);
    issue_cmd(KIND_READ,   7'd0,  6'd0,  6'd63, 6'd0, 6'd0, CORNER_RD);
    in_valid <= 1'b0;
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("bitmap_shape_fill_engine test passed");
    end else begin
      $display("bitmap_shape_fill_engine test failed");
    end
    $finish;
  end

endmodule
